/* rtl/color_blink_table_core_assert.svh */
// assertion macros for the color blink table core
`ifndef COLOR_BLINK_TABLE_CORE_ASSERT_SVH
`define COLOR_BLINK_TABLE_CORE_ASSERT_SVH

// check that a condition holds at every clock edge outside reset
`define CBT_ASSERT(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// check that a condition implies another one on the next edge
`define CBT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/cbt_pkg.sv */
// types and constants for the color blink table
package cbt_pkg;

  localparam int MAX_ENTRIES = 20;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_MOVE
  } state_t;

  typedef struct packed {
    logic [11:0] idx;
    logic [23:0] off;
    logic [23:0] on;
    logic [15:0] period;
    logic [15:0] ticks;
    logic        phase;
  } entry_t;

endpackage

/* rtl/cbt_cell.sv */
// one table cell: holds an entry and passes it to its neighbor on shift
module cbt_cell
  import cbt_pkg::*;
(
  input  logic   clk,
  input  logic   shift,
  input  entry_t din,
  output entry_t dout
);

  entry_t ent;

  // load from the neighbor when the ring rotates
  always_ff @(posedge clk) begin
    if (shift) begin
      ent <= din;
    end
  end

  assign dout = ent;

endmodule

/* rtl/color_blink_table_core.sv */
// Channel  | Signals                                         | Direction
// input    | in_valid, in_stall, command .. period           | to core
// output   | out_valid, out_stall, write_color .. last       | from core
//
// The table is a ring of MaxEntries cells; one rotation visits every entry
// at the head cell, one per cycle unless an output stall holds the ring.
// Every command takes one rotation; a delete that compacts takes a second.
// Output stalls hold the ring when a tick flip cannot be sent. Reset (rst,
// synchronous) empties the table; cell contents are not cleared.
module color_blink_table_core
  import cbt_pkg::*;
#(
  parameter int MaxEntries = MAX_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [11:0] color_index,
  input  logic [7:0]  off_red,
  input  logic [7:0]  off_green,
  input  logic [7:0]  off_blue,
  input  logic [7:0]  on_red,
  input  logic [7:0]  on_green,
  input  logic [7:0]  on_blue,
  input  logic [15:0] period,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_color,
  output logic [11:0] map_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [1:0]  status,
  output logic        last
);

  `include "color_blink_table_core_assert.svh"

  localparam int CW = $clog2(MaxEntries + 1);
  localparam logic [CW-1:0] LastStep = CW'(MaxEntries - 1);

  state_t state, state_next;
  logic [CW-1:0] step, count, slot;
  cmd_t        cmd;
  logic [11:0] cmd_idx;
  logic [23:0] cmd_off, cmd_on;
  logic [15:0] cmd_per;
  logic        found, appended;
  logic [23:0] del_color;
  entry_t      hold;
  logic        held_v;
  logic [11:0] held_idx;
  logic [23:0] held_color;

  entry_t chain [MaxEntries];
  entry_t head, head_next;
  logic   shift;

  logic        live, is_last, match, flip, out_free;
  logic        phase_n;
  logic [15:0] ticks_dec;
  logic [23:0] flip_color;
  logic        emit, e_wr, e_last;
  logic [11:0] e_idx;
  logic [23:0] e_color;
  status_t     e_status;

  // ring of cells, head is cell zero, modified head re-enters at the tail
  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    if (i == MaxEntries - 1) begin : g_tail
      cbt_cell u_cell (.clk(clk), .shift(shift), .din(head_next), .dout(chain[i]));
    end else begin : g_body
      cbt_cell u_cell (.clk(clk), .shift(shift), .din(chain[i+1]), .dout(chain[i]));
    end
  end

  assign head     = chain[0];
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign live     = step < count;
  assign is_last  = step == LastStep;
  assign match    = live && (head.idx == cmd_idx) && !found;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, head update and result selection
  always_comb begin
    state_next = state;
    head_next  = head;
    shift      = 1'b0;
    flip       = 1'b0;
    phase_n    = ~head.phase;
    ticks_dec  = head.ticks - 16'd1;
    flip_color = phase_n ? head.on : head.off;
    emit       = 1'b0;
    e_wr       = 1'b0;
    e_idx      = '0;
    e_color    = '0;
    e_status   = ST_OK;
    e_last     = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        shift = 1'b1;
        case (cmd)
          CMD_SET: begin
            if (match || (step == count && !found)) begin
              head_next = '{idx: cmd_idx, off: cmd_off, on: cmd_on, period: cmd_per,
                            ticks: cmd_per, phase: 1'b0};
            end
          end
          CMD_TICK: begin
            if (live) begin
              if (ticks_dec == 16'd0) begin
                flip            = 1'b1;
                head_next.phase = phase_n;
                head_next.ticks = head.period;
                shift           = !held_v || out_free;
                if (held_v && out_free) begin
                  emit    = 1'b1;
                  e_wr    = 1'b1;
                  e_idx   = held_idx;
                  e_color = held_color;
                  e_last  = 1'b0;
                end
              end else begin
                head_next.ticks = ticks_dec;
              end
            end
          end
          default: ;
        endcase
        if (shift && is_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          case (cmd)
            CMD_SET: begin
              if (!found && !appended) begin
                e_status = ST_FULL;
              end
            end
            CMD_DEL: begin
              if (found) begin
                e_wr    = 1'b1;
                e_idx   = cmd_idx;
                e_color = del_color;
                if (slot != count - CW'(1)) begin
                  state_next = S_MOVE;
                end
              end else begin
                e_status = ST_MISSING;
              end
            end
            CMD_TICK: begin
              if (held_v) begin
                e_wr    = 1'b1;
                e_idx   = held_idx;
                e_color = held_color;
              end
            end
            default: ;
          endcase
        end
      end
      S_MOVE: begin
        shift = 1'b1;
        if (step == slot) begin
          head_next = hold;
        end
        if (is_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // scan bookkeeping, pending flip flag and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      count    <= '0;
      found    <= 1'b0;
      appended <= 1'b0;
      held_v   <= 1'b0;
    end else begin
      if (shift) begin
        step <= is_last ? '0 : step + CW'(1);
      end
      case (state)
        S_IDLE: begin
          step     <= '0;
          found    <= 1'b0;
          appended <= 1'b0;
          held_v   <= 1'b0;
        end
        S_SCAN: begin
          case (cmd)
            CMD_SET: begin
              if (match) begin
                found <= 1'b1;
              end
              if (step == count && !found) begin
                appended <= 1'b1;
              end
            end
            CMD_DEL: begin
              if (match) begin
                found <= 1'b1;
              end
            end
            CMD_TICK: begin
              if (flip && shift) begin
                held_v <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_FIN: begin
          if (out_free) begin
            held_v <= 1'b0;
            if (cmd == CMD_SET && appended) begin
              count <= count + CW'(1);
            end else if (cmd == CMD_DEL && found) begin
              count <= count - CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload captured per command and per scan step
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd     <= cmd_t'(command);
      cmd_idx <= color_index;
      cmd_off <= {off_red, off_green, off_blue};
      cmd_on  <= {on_red, on_green, on_blue};
      cmd_per <= period;
    end
    if (state == S_SCAN && cmd == CMD_DEL) begin
      if (match) begin
        slot      <= step;
        del_color <= head.off;
      end
      if (live && step == count - CW'(1)) begin
        hold <= head;
      end
    end
    if (flip && shift) begin
      held_idx   <= head.idx;
      held_color <= flip_color;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      write_color <= e_wr;
      map_index   <= e_idx;
      red         <= e_color[23:16];
      green       <= e_color[15:8];
      blue        <= e_color[7:0];
      status      <= e_status;
      last        <= e_last;
    end
  end

  `CBT_ASSERT(a_count_bound, clk, rst, count <= CW'(MaxEntries), "entry count above table size")
  `CBT_ASSERT(a_held_scope, clk, rst, !held_v || state == S_SCAN || state == S_FIN,
              "pending flip outside a tick scan")
  `CBT_ASSERT_NEXT(a_scan_end, clk, rst, state == S_SCAN && shift && is_last,
                   state == S_FIN && step == '0, "scan did not end at step zero")

endmodule

/* bench/tb.sv */
// testbench for the color blink table core
`timescale 1ns / 100ps

module tb;
  import cbt_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int Slots = MAX_ENTRIES;

  typedef struct packed {
    logic        write_color;
    logic [11:0] map_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [1:0]  status;
    logic        last;
  } map_write_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  command;
  logic [11:0] color_index;
  logic [7:0]  off_red, off_green, off_blue;
  logic [7:0]  on_red, on_green, on_blue;
  logic [15:0] period;
  logic        out_valid;
  logic        out_stall;
  logic        write_color;
  logic [11:0] map_index;
  logic [7:0]  red, green, blue;
  logic [1:0]  status;
  logic        last;

  // shadow copy of the blink table
  int          live_count;
  logic [11:0] tbl_index [Slots];
  logic [23:0] tbl_off [Slots];
  logic [23:0] tbl_on [Slots];
  logic [15:0] tbl_period [Slots];
  logic [15:0] tbl_ticks [Slots];
  logic        tbl_phase [Slots];

  map_write_t  pending_writes[$];
  int          mismatches;
  int          cycles;
  bit          calm;
  bit          out_quiet;

  color_blink_table_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .color_index(color_index),
    .off_red(off_red), .off_green(off_green), .off_blue(off_blue),
    .on_red(on_red), .on_green(on_green), .on_blue(on_blue),
    .period(period),
    .out_valid(out_valid), .out_stall(out_stall),
    .write_color(write_color), .map_index(map_index),
    .red(red), .green(green), .blue(blue),
    .status(status), .last(last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic map_write_t make_write(logic wr, logic [11:0] idx, logic [23:0] rgb,
                                            status_t st, logic lst);
    map_write_t w;
    w.write_color = wr;
    w.map_index   = wr ? idx : 12'd0;
    w.red         = wr ? rgb[23:16] : 8'd0;
    w.green       = wr ? rgb[15:8] : 8'd0;
    w.blue        = wr ? rgb[7:0] : 8'd0;
    w.status      = st;
    w.last        = lst;
    return w;
  endfunction

  function automatic int find_slot(logic [11:0] idx);
    for (int i = 0; i < live_count; i++)
      if (tbl_index[i] == idx) return i;
    return -1;
  endfunction

  // compute the map writes that one command causes
  task automatic predict_writes(cmd_t cmd, logic [11:0] idx, logic [23:0] off_rgb,
                                logic [23:0] on_rgb, logic [15:0] per);
    int slot;
    int flips;
    int first_new;
    slot = find_slot(idx);
    first_new = pending_writes.size();
    flips = 0;
    case (cmd)
      CMD_SET: begin
        if (slot < 0 && live_count >= Slots) begin
          pending_writes.push_back(make_write(1'b0, 0, 0, ST_FULL, 1'b1));
        end else begin
          if (slot < 0) begin
            slot = live_count;
            live_count++;
          end
          tbl_index[slot]  = idx;
          tbl_off[slot]    = off_rgb;
          tbl_on[slot]     = on_rgb;
          tbl_period[slot] = per;
          tbl_ticks[slot]  = per;
          tbl_phase[slot]  = 1'b0;
          pending_writes.push_back(make_write(1'b0, 0, 0, ST_OK, 1'b1));
        end
      end
      CMD_DEL: begin
        if (slot < 0) begin
          pending_writes.push_back(make_write(1'b0, 0, 0, ST_MISSING, 1'b1));
        end else begin
          pending_writes.push_back(make_write(1'b1, idx, tbl_off[slot], ST_OK, 1'b1));
          live_count--;
          tbl_index[slot]  = tbl_index[live_count];
          tbl_off[slot]    = tbl_off[live_count];
          tbl_on[slot]     = tbl_on[live_count];
          tbl_period[slot] = tbl_period[live_count];
          tbl_ticks[slot]  = tbl_ticks[live_count];
          tbl_phase[slot]  = tbl_phase[live_count];
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < live_count; i++) begin
          tbl_ticks[i] = tbl_ticks[i] - 16'd1;
          if (tbl_ticks[i] == 16'd0) begin
            tbl_phase[i] = ~tbl_phase[i];
            pending_writes.push_back(make_write(1'b1, tbl_index[i],
                tbl_phase[i] ? tbl_on[i] : tbl_off[i], ST_OK, 1'b0));
            tbl_ticks[i] = tbl_period[i];
            flips++;
          end
        end
        if (flips == 0)
          pending_writes.push_back(make_write(1'b0, 0, 0, ST_OK, 1'b1));
        else
          pending_writes[pending_writes.size() - 1].last = 1'b1;
      end
      default: pending_writes.push_back(make_write(1'b0, 0, 0, ST_OK, 1'b1));
    endcase
  endtask

  // send one beat, sometimes after a random gap
  task automatic send_command(cmd_t cmd, logic [11:0] idx, logic [23:0] off_rgb,
                              logic [23:0] on_rgb, logic [15:0] per);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    color_index <= idx;
    {off_red, off_green, off_blue} <= off_rgb;
    {on_red, on_green, on_blue}    <= on_rgb;
    period      <= per;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_writes(cmd, idx, off_rgb, on_rgb, per);
    @(negedge clk);
  endtask

  // output stall bursts
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && !out_quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each result beat
  always @(posedge clk) begin
    map_write_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {write_color, map_index, red, green, blue, status, last};
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", got));
      end else begin
        want = pending_writes.pop_front();
        if (got.write_color !== want.write_color) report_mismatch("write_color");
        if (got.map_index !== want.map_index)
          report_mismatch($sformatf("map_index %h want %h", got.map_index, want.map_index));
        if (got.red !== want.red) report_mismatch("red");
        if (got.green !== want.green) report_mismatch("green");
        if (got.blue !== want.blue) report_mismatch("blue");
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
        if (got.last !== want.last) report_mismatch("last");
      end
    end
  end

  function automatic logic [23:0] any_rgb();
    return 24'($urandom);
  endfunction

  // extremes, every command, full table, missing entry, nop
  task automatic test_directed();
    send_command(CMD_TICK, 0, 0, 0, 1);
    send_command(CMD_DEL, 12'hFFF, 0, 0, 1);
    send_command(CMD_SET, 12'hFFF, 24'hFFFFFF, 24'h000000, 16'd1);
    send_command(CMD_SET, 12'h000, 24'h000000, 24'hFFFFFF, 16'hFFFF);
    send_command(CMD_SET, 12'h555, 24'hA5A5A5, 24'h5A5A5A, 16'd2);
    send_command(CMD_TICK, 0, 0, 0, 1);
    send_command(CMD_TICK, 0, 0, 0, 1);
    send_command(CMD_SET, 12'h555, 24'h123456, 24'h654321, 16'd1);
    send_command(CMD_NOP, 12'hAAA, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_command(CMD_DEL, 12'hFFF, 0, 0, 1);
    send_command(CMD_TICK, 0, 0, 0, 1);
    send_command(CMD_SET, 12'h0AA, 24'h010203, 24'h040506, 16'd0);
    for (int i = 0; i < Slots - 2; i++)
      send_command(CMD_SET, 12'(12'h100 + i), any_rgb(), any_rgb(), 16'd1);
    send_command(CMD_SET, 12'h7FF, any_rgb(), any_rgb(), 16'd3);
    send_command(CMD_TICK, 0, 0, 0, 1);
    send_command(CMD_DEL, 12'h000, 0, 0, 1);
  endtask

  // random commands over a small index pool so hits and misses mix
  task automatic test_random(int count);
    cmd_t cmd;
    logic [11:0] idx;
    logic [15:0] per;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      cmd = pick < 4 ? CMD_TICK : pick < 7 ? CMD_SET : pick < 9 ? CMD_DEL : CMD_NOP;
      idx = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 29));
      per = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(1, 4));
      send_command(cmd, idx, any_rgb(), any_rgb(), per);
    end
  endtask

  initial begin
    cycles = 0;
    mismatches = 0;
    live_count = 0;
    calm = 1'b0;
    out_quiet = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_NOP;
    color_index = '0;
    {off_red, off_green, off_blue} = '0;
    {on_red, on_green, on_blue} = '0;
    period = 16'd1;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(57);
    calm = 1'b1;
    test_random(30);
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (4 * Slots + 20) @(negedge clk);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
